// File: rtl/core/crce_pkg.sv
// ----------------------------------------------------------------------------
// crce_pkg
// Shared constants, register indexes, datapath step codes and the command
// and status structs used between the curve evaluator's controller and
// datapath.
// ----------------------------------------------------------------------------
package crce_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_POINTS = 7;
    localparam int DEF_FRAC_BITS  = 12;

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FIRST = 4'd1;

    // Point count handling.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd2;

    // Saturation limits of the result.
    localparam logic [SAMPLE_W-1:0] VALUE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] VALUE_MIN = 16'h8000;

    // Datapath step codes.
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_START    = 4'd1;
    localparam t_op OP_CHECK_LO = 4'd2;
    localparam t_op OP_CHECK_HI = 4'd3;
    localparam t_op OP_SCAN     = 4'd4;
    localparam t_op OP_FETCH0   = 4'd5;
    localparam t_op OP_FETCH1   = 4'd6;
    localparam t_op OP_FETCH2   = 4'd7;
    localparam t_op OP_FETCH3   = 4'd8;
    localparam t_op OP_DIV      = 4'd9;
    localparam t_op OP_MUL_LO   = 4'd10;
    localparam t_op OP_MUL_HI   = 4'd11;
    localparam t_op OP_FINISH   = 4'd12;

    // Term added after each Horner multiply.
    typedef logic [1:0] t_term;
    localparam t_term TERM_B = 2'd0;
    localparam t_term TERM_A = 2'd1;
    localparam t_term TERM_Y = 2'd2;

    typedef struct packed {
        t_op   op;
        t_term term;
    } t_dp_cmd;

    typedef struct packed {
        logic below_first;
        logic at_or_above;
        logic scan_more;
    } t_dp_sts;

endpackage

// File: rtl/core/crce_ctrl.sv
// ----------------------------------------------------------------------------
// crce_ctrl
// Sequencer for the curve evaluator: range checks, segment scan, point
// fetch, serial divide and the shared-multiplier Horner steps.
// ----------------------------------------------------------------------------
module crce_ctrl #(
    parameter int FRAC_BITS = crce_pkg::DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    input  crce_pkg::t_dp_sts i_sts,
    output crce_pkg::t_dp_cmd o_cmd
);
    import crce_pkg::*;

    localparam int CNT_W     = $clog2(FRAC_BITS);
    localparam int MSTEP_W   = 3;
    localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(FRAC_BITS - 1);
    localparam logic [MSTEP_W-1:0] MUL_LAST = 3'd5;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LO   = 4'd1;
    localparam logic [3:0] S_HI   = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_F0   = 4'd4;
    localparam logic [3:0] S_F1   = 4'd5;
    localparam logic [3:0] S_F2   = 4'd6;
    localparam logic [3:0] S_F3   = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [MSTEP_W-1:0] r_mstep, n_mstep;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_mstep    = r_mstep;
        o_cmd.op   = OP_NONE;
        o_cmd.term = r_mstep[2:1];
        case (r_state)
            S_IDLE, S_OUT: begin
                if (i_start) begin
                    o_cmd.op = OP_START;
                    n_state  = S_LO;
                end else begin
                    n_state  = S_IDLE;
                end
            end
            S_LO: begin
                o_cmd.op = OP_CHECK_LO;
                n_state  = i_sts.below_first ? S_OUT : S_HI;
            end
            S_HI: begin
                o_cmd.op = OP_CHECK_HI;
                n_state  = i_sts.at_or_above ? S_OUT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (!i_sts.scan_more) begin
                    n_state = S_F0;
                end
            end
            S_F0: begin
                o_cmd.op = OP_FETCH0;
                n_state  = S_F1;
            end
            S_F1: begin
                o_cmd.op = OP_FETCH1;
                n_state  = S_F2;
            end
            S_F2: begin
                o_cmd.op = OP_FETCH2;
                n_state  = S_F3;
            end
            S_F3: begin
                o_cmd.op = OP_FETCH3;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_cnt == DIV_LAST) begin
                    n_mstep = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.op = r_mstep[0] ? OP_MUL_HI : OP_MUL_LO;
                if (r_mstep == MUL_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_mstep = r_mstep + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mstep <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mstep <= n_mstep;
        end
    end

    assign o_busy = (r_state != S_IDLE) && (r_state != S_OUT);
    assign o_done = (r_state == S_OUT);

endmodule

// File: rtl/core/crce_dp.sv
// ----------------------------------------------------------------------------
// crce_dp
// Datapath of the curve evaluator: point registers with one read port,
// segment pointer, restoring divider and a shared limb multiplier that
// runs the Horner evaluation of the cubic.
// ----------------------------------------------------------------------------
module crce_dp #(
    parameter int MAX_POINTS = crce_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = crce_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  crce_pkg::t_dp_cmd                 i_cmd,
    output crce_pkg::t_dp_sts                 o_sts,
    input  logic signed [crce_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_cfg_we,
    input  logic [crce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [crce_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [crce_pkg::SAMPLE_W-1:0]     o_value,
    output logic                              o_saturated
);
    import crce_pkg::*;

    localparam int PTR_W   = $clog2(MAX_POINTS);
    localparam int NUM_W   = SAMPLE_W + 1;
    localparam int A_W     = SAMPLE_W + 1;
    localparam int COEF_W  = SAMPLE_W + 4;
    localparam int YT_W    = SAMPLE_W + 2;
    // Accumulator holds the full numerator plus the rounding offset.
    localparam int AW      = 3 * FRAC_BITS + COEF_W + 2;
    localparam int LW      = (AW + 1) / 2;
    localparam int HW      = AW - LW;
    localparam int MOPW    = LW + 1;
    localparam int PW      = MOPW + FRAC_BITS + 1;
    localparam int RES_LSB = 3 * FRAC_BITS + 1;
    localparam int RES_W   = AW - RES_LSB;

    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_TWO = PTR_W'(2);

    function automatic logic signed [COEF_W-1:0] ext_coef(input logic signed [SAMPLE_W-1:0] v);
        ext_coef = {{(COEF_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    // Configuration registers.
    logic [COUNT_W-1:0]    r_count;
    logic [CFG_DATA_W-1:0] r_points [MAX_POINTS];
    logic [CFG_IDX_W-1:0]  w_widx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_points[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_POINT_COUNT) begin
                r_count <= i_cfg_data[COUNT_W-1:0];
            end else if (i_cfg_index <= CFG_IDX_W'(MAX_POINTS)) begin
                r_points[w_widx[PTR_W-1:0]] <= i_cfg_data;
            end
        end
    end

    assign w_widx = i_cfg_index - REG_POINT_FIRST;

    // Effective last point index.
    logic [COUNT_W-1:0] w_n, w_n_m1;
    logic [PTR_W-1:0]   w_last;

    always_comb begin
        if (r_count < COUNT_MIN) begin
            w_n = COUNT_MIN;
        end else if (r_count > COUNT_W'(MAX_POINTS)) begin
            w_n = COUNT_W'(MAX_POINTS);
        end else begin
            w_n = r_count;
        end
    end

    assign w_n_m1 = w_n - COUNT_W'(1);
    assign w_last = w_n_m1[PTR_W-1:0];

    // Working registers.
    logic signed [SAMPLE_W-1:0] r_sample, r_x1, r_y0, r_y1, r_y2;
    logic [PTR_W-1:0]           r_ptr, r_seg;
    logic signed [NUM_W-1:0]    r_num, r_den;
    logic signed [A_W-1:0]      r_a;
    logic signed [COEF_W-1:0]   r_b;
    logic [NUM_W-1:0]           r_rem;
    logic [FRAC_BITS-1:0]       r_quo;
    logic                       r_zero, r_clamp;
    logic [AW-1:0]              r_acc, r_tmp;
    logic [SAMPLE_W-1:0]        r_value;
    logic                       r_sat;

    // Single read port on the point registers.
    logic [CFG_DATA_W-1:0]      w_pt;
    logic signed [SAMPLE_W-1:0] w_x, w_y;

    assign w_pt = r_points[r_ptr];
    assign w_x  = w_pt[CFG_DATA_W-1:SAMPLE_W];
    assign w_y  = w_pt[SAMPLE_W-1:0];

    assign o_sts.below_first = (r_sample < w_x);
    assign o_sts.at_or_above = (r_sample >= w_x);
    assign o_sts.scan_more   = (r_ptr < w_last) && (w_x <= r_sample);

    // Segment offset and width.
    logic signed [NUM_W-1:0] w_num, w_den;

    assign w_num = {r_sample[SAMPLE_W-1], r_sample} - {r_x1[SAMPLE_W-1], r_x1};
    assign w_den = {w_x[SAMPLE_W-1], w_x} - {r_x1[SAMPLE_W-1], r_x1};

    // Cubic coefficients, y3 comes straight off the read port.
    logic signed [COEF_W-1:0] e0, e1, e2, e3, w_b, w_c;
    logic signed [A_W-1:0]    w_a;

    always_comb begin
        e0  = ext_coef(r_y0);
        e1  = ext_coef(r_y1);
        e2  = ext_coef(r_y2);
        e3  = ext_coef(w_y);
        w_a = {r_y2[SAMPLE_W-1], r_y2} - {r_y0[SAMPLE_W-1], r_y0};
        w_b = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        w_c = e3 - e0 + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2);
    end

    // Restoring divider step.
    logic [NUM_W-1:0] w_rem2;
    logic [NUM_W:0]   w_diff;

    assign w_rem2 = {r_rem[NUM_W-2:0], 1'b0};
    assign w_diff = {1'b0, w_rem2} - {1'b0, r_den};

    // Local parameter.
    logic [FRAC_BITS-1:0] w_u;

    always_comb begin
        if (r_zero) begin
            w_u = '0;
        end else if (r_clamp) begin
            w_u = '1;
        end else begin
            w_u = r_quo;
        end
    end

    // Shared multiplier: one accumulator limb times u.
    logic signed [MOPW-1:0]      w_mop;
    logic signed [FRAC_BITS:0]   w_uop;
    logic signed [PW-1:0]        w_prod;
    logic [AW-1:0]               w_prod_ext, w_prod_hi, w_k;
    logic signed [YT_W-1:0]      w_yt;

    always_comb begin
        if (i_cmd.op == OP_MUL_HI) begin
            w_mop = {{(MOPW-HW){r_acc[AW-1]}}, r_acc[AW-1:LW]};
        end else begin
            w_mop = {1'b0, r_acc[LW-1:0]};
        end
    end

    assign w_uop      = {1'b0, w_u};
    assign w_prod     = w_mop * w_uop;
    assign w_prod_ext = {{(AW-PW){w_prod[PW-1]}}, w_prod};
    assign w_prod_hi  = {w_prod_ext[HW-1:0], {LW{1'b0}}};
    assign w_yt       = ({{2{r_y1[SAMPLE_W-1]}}, r_y1} <<< 1) + YT_W'(1);

    always_comb begin
        case (i_cmd.term)
            TERM_B:  w_k = {{(AW-COEF_W-FRAC_BITS){r_b[COEF_W-1]}}, r_b, {FRAC_BITS{1'b0}}};
            TERM_A:  w_k = {{(AW-A_W-2*FRAC_BITS){r_a[A_W-1]}}, r_a, {(2*FRAC_BITS){1'b0}}};
            default: w_k = {{(AW-YT_W-3*FRAC_BITS){w_yt[YT_W-1]}}, w_yt,
                            {(3*FRAC_BITS){1'b0}}};
        endcase
    end

    // Rounded and saturated result.
    logic [RES_W-1:0] w_res;
    logic             w_ovf;

    assign w_res = r_acc[AW-1:RES_LSB];
    assign w_ovf = !(&w_res[RES_W-1:SAMPLE_W-1]) && (|w_res[RES_W-1:SAMPLE_W-1]);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_sample <= i_sample;
                r_ptr    <= '0;
            end
            OP_CHECK_LO: begin
                if (o_sts.below_first) begin
                    r_value <= w_y;
                    r_sat   <= 1'b0;
                end
                r_ptr <= w_last;
            end
            OP_CHECK_HI: begin
                if (o_sts.at_or_above) begin
                    r_value <= w_y;
                    r_sat   <= 1'b0;
                end
                r_ptr <= PTR_ONE;
            end
            OP_SCAN: begin
                if (o_sts.scan_more) begin
                    r_ptr <= r_ptr + PTR_ONE;
                end else begin
                    r_seg <= r_ptr;
                    r_ptr <= (r_ptr > PTR_ONE) ? r_ptr - PTR_TWO : '0;
                end
            end
            OP_FETCH0: begin
                r_y0  <= w_y;
                r_ptr <= r_seg - PTR_ONE;
            end
            OP_FETCH1: begin
                r_y1  <= w_y;
                r_x1  <= w_x;
                r_ptr <= r_seg;
            end
            OP_FETCH2: begin
                r_y2  <= w_y;
                r_num <= w_num;
                r_den <= w_den;
                r_ptr <= (r_seg < w_last) ? r_seg + PTR_ONE : w_last;
            end
            OP_FETCH3: begin
                r_a     <= w_a;
                r_b     <= w_b;
                r_acc   <= {{(AW-COEF_W){w_c[COEF_W-1]}}, w_c};
                r_rem   <= r_num;
                r_quo   <= '0;
                r_zero  <= r_den[NUM_W-1] || (r_den == '0) || r_num[NUM_W-1] || (r_num == '0);
                r_clamp <= (r_num >= r_den);
            end
            OP_DIV: begin
                if (!w_diff[NUM_W]) begin
                    r_rem <= w_diff[NUM_W-1:0];
                end else begin
                    r_rem <= w_rem2;
                end
                r_quo <= {r_quo[FRAC_BITS-2:0], !w_diff[NUM_W]};
            end
            OP_MUL_LO: begin
                r_tmp <= w_prod_ext;
            end
            OP_MUL_HI: begin
                r_acc <= w_prod_hi + r_tmp + w_k;
            end
            OP_FINISH: begin
                r_sat <= w_ovf;
                if (w_ovf) begin
                    r_value <= w_res[RES_W-1] ? VALUE_MIN : VALUE_MAX;
                end else begin
                    r_value <= w_res[SAMPLE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_value     = r_value;
    assign o_saturated = r_sat;

endmodule

// File: rtl/core/catmull_rom_curve_eval.sv
// ----------------------------------------------------------------------------
// catmull_rom_curve_eval: Catmull-Rom curve lookup over up to seven points.
// A request below the first point or at or above the last ends after the range
// checks; any other goes through the one-point-a-cycle segment scan, the
// one-bit-a-cycle divider and six passes through the shared multiplier. A new
// start is taken in the done cycle; results cannot be stalled.
// Synchronous reset idles the sequencer, sets point_count to 2, clears points.
// ----------------------------------------------------------------------------
module catmull_rom_curve_eval #(
    parameter int MAX_POINTS = crce_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = crce_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Request channel: a request is taken when start is high and busy low.
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [crce_pkg::SAMPLE_W-1:0] i_sample,

    // Result channel: valid for exactly the cycle in which o_done is high.
    output logic                                 o_done,
    output logic signed [crce_pkg::SAMPLE_W-1:0] o_value,
    output logic                                 o_saturated,

    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [crce_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [crce_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import crce_pkg::*;

    // The controller and datapath talk only through these two structs. The
    // controller decides the order of steps from three status flags: sample
    // below the point on the read port, sample at or above it, and whether the
    // segment scan must advance.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Point registers are plain flops with no side effects on a write, so the
    // configuration channel never needs to push back.
    assign o_cfg_ready = 1'b1;

    // The sequencer walks each request through: a check against the first
    // point, a check against the last point, a scan for the segment, four
    // point fetches (outer low, low, high, outer high, with the outer
    // neighbours clamped at both ends), FRAC_BITS restoring divide steps for
    // the local parameter, and three Horner steps of two multiplier passes
    // each. The done cycle also accepts the next request.
    crce_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath evaluates the cubic exactly in a wide accumulator. Each
    // Horner multiply by the local parameter splits the accumulator into a
    // low and a high limb so that one multiplier of 30 by 13 bits (default FRAC_BITS)
    // serves all steps. The final rounding is a plain arithmetic shift of the
    // accumulator, since the half-unit offset rides in with the last term.
    crce_dp #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );

endmodule

// File: rtl/core/crce_checker.sv
// ----------------------------------------------------------------------------
// crce_checker
// Port-level checks on the curve evaluator's request and result sequencing,
// bound to the top level.
// ----------------------------------------------------------------------------
module crce_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [crce_pkg::SAMPLE_W-1:0] o_value,
    input logic                          o_saturated
);
    import crce_pkg::*;

    // An accepted request always puts the block to work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Work only ends by delivering a result.
    a_busy_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (busy || o_done))
        else $error("busy dropped without a result");

    // The result cycle is open for the next request.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy asserted during the result cycle");

    // Without a new request the block falls idle after a result.
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !start) |=> (!busy && !o_done))
        else $error("activity after a result with no request");

    // A clipped result sits at one of the two limits.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |-> (o_value == VALUE_MAX || o_value == VALUE_MIN))
        else $error("saturated result not at a limit");

endmodule

bind catmull_rom_curve_eval crce_checker u_crce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_value     (o_value),
    .o_saturated (o_saturated)
);
